// ===== hw/rtl/r2fft_pkg.sv =====
// shared types, constants and twiddle table for the radix-2 fft
package r2fft_pkg;

    localparam int unsigned DATA_W = 24;
    localparam int unsigned SMP_W  = 16;
    localparam int unsigned TW_W   = 16;
    localparam int unsigned ADDR_W = 6;
    localparam int unsigned STG_W  = 3;

    // datapath commands from the controller
    typedef struct packed {
        logic              load_wr;
        logic [ADDR_W-1:0] load_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_sel_b;
        logic              cap_u;
        logic              cap_x;
        logic              do_mul;
        logic              do_add;
        logic [4:0]        tw_k;
    } t_dp_cmd;

    // round(32767*cos(2*pi*k/64)), k = 0..16
    function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] k);
        logic signed [TW_W-1:0] v;
        case (k)
            5'd0:  v = 16'sd32767;
            5'd1:  v = 16'sd32609;
            5'd2:  v = 16'sd32137;
            5'd3:  v = 16'sd31356;
            5'd4:  v = 16'sd30273;
            5'd5:  v = 16'sd28898;
            5'd6:  v = 16'sd27245;
            5'd7:  v = 16'sd25329;
            5'd8:  v = 16'sd23170;
            5'd9:  v = 16'sd20787;
            5'd10: v = 16'sd18204;
            5'd11: v = 16'sd15446;
            5'd12: v = 16'sd12539;
            5'd13: v = 16'sd9512;
            5'd14: v = 16'sd6393;
            5'd15: v = 16'sd3212;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // real part of exp(-j*2*pi*k/64), k = 0..31
    function automatic logic signed [TW_W-1:0] tw_re(input logic [4:0] k);
        logic signed [TW_W-1:0] v;
        if (k <= 5'd16) begin
            v = quarter_cos(k);
        end else begin
            v = -quarter_cos(5'(6'd32 - {1'b0, k}));
        end
        return v;
    endfunction

    // imaginary part of exp(-j*2*pi*k/64), k = 0..31
    function automatic logic signed [TW_W-1:0] tw_im(input logic [4:0] k);
        logic signed [TW_W-1:0] v;
        if (k >= 5'd16) begin
            v = -quarter_cos(k - 5'd16);
        end else begin
            v = -quarter_cos(5'd16 - k);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/r2fft_ram.sv =====
// generic single-port-write ram with registered read
module r2fft_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/r2fft_dp.sv =====
// butterfly datapath: work store, complex multiply, add/subtract
module r2fft_dp
    import r2fft_pkg::*;
(
    input  logic                     i_clk,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [SMP_W-1:0]  i_sample,
    output logic signed [DATA_W-1:0] o_rd_re,
    output logic signed [DATA_W-1:0] o_rd_im
);

    logic [2*DATA_W-1:0] ram_wdata;
    logic [2*DATA_W-1:0] ram_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;

    logic signed [DATA_W-1:0] r_u_re, r_u_im, r_x_re, r_x_im;
    logic signed [DATA_W-1:0] r_t_re, r_t_im;
    logic signed [DATA_W-1:0] r_a_re, r_a_im, r_b_re, r_b_im;
    logic signed [TW_W-1:0]   wr, wi;
    logic signed [47:0]       p_re, p_im;
    logic signed [47:0]       q_re, q_im;

    assign o_rd_re = ram_rdata[2*DATA_W-1:DATA_W];
    assign o_rd_im = ram_rdata[DATA_W-1:0];

    r2fft_ram #(.WIDTH(2*DATA_W), .DEPTH(64)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (ram_rdata)
    );

    // write mux: sample load or butterfly result
    always_comb begin
        ram_we    = i_cmd.load_wr | i_cmd.wr_en;
        ram_waddr = i_cmd.load_wr ? i_cmd.load_addr : i_cmd.wr_addr;
        if (i_cmd.load_wr) begin
            ram_wdata = {DATA_W'(i_sample), {DATA_W{1'b0}}};
        end else if (i_cmd.wr_sel_b) begin
            ram_wdata = {r_b_re, r_b_im};
        end else begin
            ram_wdata = {r_a_re, r_a_im};
        end
    end

    // twiddle and complex products, rounded half up
    always_comb begin
        wr   = tw_re(i_cmd.tw_k);
        wi   = tw_im(i_cmd.tw_k);
        p_re = 48'(wr * r_x_re) - 48'(wi * r_x_im) + 48'sd16384;
        p_im = 48'(wr * r_x_im) + 48'(wi * r_x_re) + 48'sd16384;
        q_re = p_re >>> 15;
        q_im = p_im >>> 15;
    end

    // operand capture, product and butterfly registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_u) begin
            r_u_re <= o_rd_re;
            r_u_im <= o_rd_im;
        end
        if (i_cmd.cap_x) begin
            r_x_re <= o_rd_re;
            r_x_im <= o_rd_im;
        end
        if (i_cmd.do_mul) begin
            r_t_re <= q_re[DATA_W-1:0];
            r_t_im <= q_im[DATA_W-1:0];
        end
        if (i_cmd.do_add) begin
            r_a_re <= r_u_re + r_t_re;
            r_a_im <= r_u_im + r_t_im;
            r_b_re <= r_u_re - r_t_re;
            r_b_im <= r_u_im - r_t_im;
        end
    end

endmodule

// ===== hw/rtl/r2fft_ctrl.sv =====
// controller: load, butterfly sequencing and bin readout
module r2fft_ctrl
    import r2fft_pkg::*;
#(
    parameter int unsigned POINTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_load,
    output logic [ADDR_W-1:0] o_out_index,
    output logic              o_out_last,
    output t_dp_cmd           o_cmd
);

    localparam int unsigned LOGN = $clog2(POINTS);

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_RDU  = 4'd1;
    localparam logic [3:0] ST_RDX  = 4'd2;
    localparam logic [3:0] ST_CAPX = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_ADD  = 4'd6;
    localparam logic [3:0] ST_WRA  = 4'd7;
    localparam logic [3:0] ST_WRB  = 4'd8;
    localparam logic [3:0] ST_ORD  = 4'd9;
    localparam logic [3:0] ST_OCAP = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [STG_W-1:0]  r_stg, n_stg;
    logic [ADDR_W-1:0] r_bf, n_bf;
    logic [ADDR_W-1:0] r_oidx, n_oidx;

    logic [ADDR_W-1:0] rev_cnt;
    logic [ADDR_W-1:0] half, jj, grp, a_addr, b_addr, kk;
    logic [ADDR_W:0]   bf_next;
    logic              last_bf, in_acc;

    // bit-reversed load address over LOGN bits
    always_comb begin
        rev_cnt = '0;
        for (int i = 0; i < LOGN; i++) begin
            rev_cnt[i] = r_cnt[LOGN-1-i];
        end
    end

    // butterfly addressing: stage s = r_stg+1, half = 2^r_stg
    always_comb begin
        half    = ADDR_W'(1) << r_stg;
        jj      = r_bf & (half - ADDR_W'(1));
        grp     = (r_bf >> r_stg) << (r_stg + STG_W'(1));
        a_addr  = grp | jj;
        b_addr  = a_addr | half;
        kk      = jj << (STG_W'(5) - r_stg);
        bf_next = {1'b0, r_bf} + 1'b1;
        last_bf = (bf_next == (ADDR_W+1)'(POINTS / 2));
    end

    assign in_acc = (r_state == ST_LOAD) && i_in_valid;

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_stg   = r_stg;
        n_bf    = r_bf;
        n_oidx  = r_oidx;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (r_cnt == ADDR_W'(POINTS - 1)) begin
                        n_cnt   = '0;
                        n_stg   = '0;
                        n_bf    = '0;
                        n_state = ST_RDU;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_RDU:  n_state = ST_RDX;
            ST_RDX:  n_state = ST_CAPX;
            ST_CAPX: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_WRA;
            ST_WRA:  n_state = ST_WRB;
            ST_WRB: begin
                if (!last_bf) begin
                    n_bf    = bf_next[ADDR_W-1:0];
                    n_state = ST_RDU;
                end else if (r_stg == STG_W'(LOGN - 1)) begin
                    n_oidx  = '0;
                    n_state = ST_ORD;
                end else begin
                    n_bf    = '0;
                    n_stg   = r_stg + 1'b1;
                    n_state = ST_RDU;
                end
            end
            ST_ORD:  n_state = ST_OCAP;
            ST_OCAP: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_oidx == ADDR_W'(POINTS - 1)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_oidx  = r_oidx + 1'b1;
                        n_state = ST_ORD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_stg   <= '0;
            r_bf    <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stg   <= n_stg;
            r_bf    <= n_bf;
            r_oidx  <= n_oidx;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_wr   = in_acc;
        o_cmd.load_addr = rev_cnt;
        o_cmd.tw_k      = kk[4:0];
        case (r_state)
            ST_RDU: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = a_addr;
            end
            ST_RDX: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = b_addr;
                o_cmd.cap_u   = 1'b1;
            end
            ST_CAPX: o_cmd.cap_x  = 1'b1;
            ST_MUL:  o_cmd.do_mul = 1'b1;
            ST_ADD:  o_cmd.do_add = 1'b1;
            ST_WRA: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = a_addr;
            end
            ST_WRB: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = b_addr;
                o_cmd.wr_sel_b = 1'b1;
            end
            ST_ORD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_oidx;
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_load  = (r_state == ST_OCAP);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_index = r_oidx;
    assign o_out_last  = (r_oidx == ADDR_W'(POINTS - 1));

    // checks
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input ready while emitting bins");
    a_last_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_last) |=> o_in_ready)
        else $error("no return to load after last bin");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_wr && o_cmd.wr_en)) else $error("load and butterfly write clash");
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg <= STG_W'(LOGN - 1)) else $error("stage counter out of range");

endmodule

// ===== hw/rtl/radix2_fft_real_input.sv =====
// top level of the radix-2 real-input fft
//
//  channel | signals                                          | direction
//  input   | i_in_valid, o_in_ready, i_sample                 | in
//  output  | o_out_valid, i_out_ready, o_bin_real, o_bin_imag,
//          | o_bin_index, o_last                               | out
//
// samples load while o_in_ready is high; the frame's last sample starts the
// butterflies, POINTS/2*log2(POINTS) of them, all on one shared butterfly;
// the bins then leave through the single store read port, and no new frame
// is taken until the last bin has gone.
// synchronous active-low reset returns to loading; store contents persist.
// an output stall holds the bin and freezes readout; input waits meanwhile.
module radix2_fft_real_input
    import r2fft_pkg::*;
#(
    parameter int unsigned POINTS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [SMP_W-1:0]  i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_bin_real,
    output logic signed [DATA_W-1:0] o_bin_imag,
    output logic [ADDR_W-1:0]        o_bin_index,
    output logic                     o_last
);

    t_dp_cmd                  cmd;
    logic                     out_load;
    logic [ADDR_W-1:0]        out_index;
    logic                     out_last;
    logic signed [DATA_W-1:0] rd_re, rd_im;
    logic signed [DATA_W-1:0] r_re, r_im;

    r2fft_ctrl #(.POINTS(POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_load  (out_load),
        .o_out_index (out_index),
        .o_out_last  (out_last),
        .o_cmd       (cmd)
    );

    r2fft_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_sample (i_sample),
        .o_rd_re  (rd_re),
        .o_rd_im  (rd_im)
    );

    // output bin register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_re <= rd_re;
            r_im <= rd_im;
        end
    end

    assign o_bin_real  = r_re;
    assign o_bin_imag  = r_im;
    assign o_bin_index = out_index;
    assign o_last      = out_last;

endmodule

// ===== tb/sv/radix2_fft_real_input_tb.sv =====
// testbench for the radix-2 real-input fft: frames of fixed and random samples, bin-by-bin check
module radix2_fft_real_input_tb;
    import r2fft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POINTS = 64;
    localparam int unsigned LOGN   = $clog2(POINTS);

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [ADDR_W-1:0]        idx;
        logic                     last;
    } t_bin;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [SMP_W-1:0]  i_sample;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_bin_real;
    logic signed [DATA_W-1:0] o_bin_imag;
    logic [ADDR_W-1:0]        o_bin_index;
    logic                     o_last;

    radix2_fft_real_input #(.POINTS(POINTS)) DUT (.*);

    logic signed [SMP_W-1:0] sample_q[$];
    t_bin                    bin_q[$];
    int                      error_count;
    int                      bins_seen;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    bit                      hold_start;
    logic                    hold_on;
    logic signed [DATA_W-1:0] frame_re[POINTS];
    logic signed [DATA_W-1:0] frame_im[POINTS];
    int unsigned             frame_fill;

    // twiddle for exp(-j*2*pi*k/64), built from the cosine quadrant
    function automatic int quad_cos(int k);
        int tab[17] = '{32767, 32609, 32137, 31356, 30273, 28898, 27245, 25329,
                        23170, 20787, 18204, 15446, 12539, 9512, 6393, 3212, 0};
        return tab[k];
    endfunction

    function automatic logic signed [DATA_W-1:0] q15_round(longint v);
        return DATA_W'((v + 64'sd16384) >>> 15);
    endfunction

    // accept one sample; on frame completion run the fft and queue all bins
    task automatic take_sample(logic signed [SMP_W-1:0] s);
        int unsigned pos, m, half, k, j, a, b, tk;
        longint wr, wi, xr, xi;
        logic signed [DATA_W-1:0] tr, ti, ur, ui;
        t_bin bn;
        pos = 0;
        for (int i = 0; i < LOGN; i++) pos |= ((frame_fill >> i) & 1) << (LOGN - 1 - i);
        frame_re[pos] = DATA_W'(s);
        frame_im[pos] = '0;
        frame_fill++;
        if (frame_fill < POINTS) return;
        frame_fill = 0;
        for (int s2 = 1; s2 <= LOGN; s2++) begin
            m = 1 << s2;
            half = m >> 1;
            for (j = 0; j < half; j++) begin
                tk = (j * (64 >> s2)) & 31;
                wr = (tk <= 16) ? quad_cos(tk) : -quad_cos(32 - tk);
                wi = -quad_cos((tk >= 16) ? tk - 16 : 16 - tk);
                for (k = j; k + half < POINTS; k += m) begin
                    a = k;
                    b = k + half;
                    xr = frame_re[b];
                    xi = frame_im[b];
                    tr = q15_round(wr * xr - wi * xi);
                    ti = q15_round(wr * xi + wi * xr);
                    ur = frame_re[a];
                    ui = frame_im[a];
                    frame_re[a] = ur + tr;
                    frame_im[a] = ui + ti;
                    frame_re[b] = ur - tr;
                    frame_im[b] = ui - ti;
                end
            end
        end
        for (int n = 0; n < POINTS; n++) begin
            bn.re = frame_re[n];
            bn.im = frame_im[n];
            bn.idx = ADDR_W'(n);
            bn.last = (n == POINTS - 1);
            bin_q.push_back(bn);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) take_sample(i_sample);
            if ((!i_in_valid || o_in_ready) && sample_q.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_sample <= sample_q.pop_front();
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor and ready
    always @(posedge i_clk) begin
        t_bin want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                bins_seen++;
                if (bin_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected bin %0d", o_bin_index));
                end else begin
                    want = bin_q.pop_front();
                    if (o_bin_real !== want.re)
                        report_mismatch($sformatf("bin %0d real %0d want %0d",
                            want.idx, o_bin_real, want.re));
                    if (o_bin_imag !== want.im)
                        report_mismatch($sformatf("bin %0d imag %0d want %0d",
                            want.idx, o_bin_imag, want.im));
                    if (o_bin_index !== want.idx)
                        report_mismatch($sformatf("index %0d want %0d",
                            o_bin_index, want.idx));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("bin %0d last %0b", want.idx, o_last));
                end
            end
            if (hold_on) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // long receiver hold-off, counted in cycles, while samples keep coming
    initial begin
        hold_on = 1'b0;
        wait (hold_start);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // queue one frame of samples; kind picks the content
    task automatic queue_frame(int kind);
        for (int n = 0; n < POINTS; n++) begin
            case (kind)
                0: sample_q.push_back(16'sh7fff);
                1: sample_q.push_back(16'sh8000);
                2: sample_q.push_back(n[0] ? 16'sh8000 : 16'sh7fff);
                3: sample_q.push_back(n == 0 ? 16'sh7fff : 16'sh0000);
                default: sample_q.push_back(16'($urandom));
            endcase
        end
    endtask

    task automatic drain_phase();
        while (sample_q.size() > 0 || bin_q.size() > 0 || frame_fill != 0
               || i_in_valid) @(posedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        bins_seen = 0;
        frame_fill = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // no idling: negative full scale, then random samples held off by a long stall
        hold_start = 1'b1;
        queue_frame(1);
        queue_frame(4);
        while (bins_seen < POINTS) @(posedge i_clk);
        // sender idling while the random frame loads
        send_idle_pct = 76;
        while (sample_q.size() > 0 || i_in_valid) @(posedge i_clk);
        // receiver stalling on its bins, nyquist frame at full scale loads next
        send_idle_pct = 0;
        recv_stall_pct = 76;
        queue_frame(2);
        while (bins_seen < 2 * POINTS) @(posedge i_clk);
        // both sides idling
        send_idle_pct = 22;
        recv_stall_pct = 22;
        drain_phase();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && bin_q.size() == 0) begin
            $display("radix2_fft_real_input verification clean");
        end else begin
            $display("radix2_fft_real_input verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("radix2_fft_real_input verification failed");
        $finish;
    end

endmodule
